// ===== hdl/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants of the Sobel gradient magnitude unit
// Pixel and window types, per-result tags, register indexes and the
// digit step of the saturating integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgm_pkg;

   // One pixel: channel a in bits 7:0, b in 15:8, c in 23:16.
   localparam int PIX_W    = 24;
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;
   localparam int WIN_N    = 9;
   localparam int POS_W    = 11;   // width of the reported row and column
   localparam int SIZE_W   = 12;   // width of the size registers
   localparam int MIN_SIZE = 3;

   localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef logic [PIX_W-1:0] pix_type;

   // Column-major 3x3 neighborhood: entry col*3 + row, column 0 is the left.
   typedef pix_type [WIN_N-1:0] win_type;

   typedef struct packed {
      logic             emit;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } meta_type;

   // Partial result of the digit-by-digit square root.
   typedef struct packed {
      logic [9:0] rem;
      logic [7:0] root;
   } sqrt_type;

   // One restoring step: bring down the next two bits of the radicand and
   // try to append a one to the root.
   function automatic sqrt_type sqrt_step(input sqrt_type acc, input logic [1:0] pair);
      logic [11:0] r2;
      logic [11:0] trial;
      sqrt_type    res;
      r2    = {acc.rem, pair};
      trial = {2'b00, acc.root, 2'b01};
      if (r2 >= trial) begin
         res.rem  = 10'(r2 - trial);
         res.root = {acc.root[6:0], 1'b1};
      end else begin
         res.rem  = r2[9:0];
         res.root = {acc.root[6:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// ===== hdl/sobel_gradient_magnitude_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_3x3_unit: 3x3 Sobel edge magnitude, three channels
// Takes one pixel word per cycle in raster order and returns, for every
// interior pixel, floor(sqrt(gx^2 + gy^2)) saturated at 255 on each channel,
// tagged with the pixel's row and column. Border pixels give no word. The
// unit sustains one pixel per clock cycle while the result side does not
// stall. The rate is set by the line memory, which holds the two previous
// rows side by side and does one read and one write-back per pixel; a write
// and a read of the same column in the same cycle are forwarded. A stall on
// the result side halts the whole pipeline and shows on req_stall in the
// same cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_gradient_magnitude_3x3_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_chan_a,
   input  logic [7:0]                         req_chan_b,
   input  logic [7:0]                         req_chan_c,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [10:0]                        rsp_out_row,
   output logic [10:0]                        rsp_out_col,
   output logic [7:0]                         rsp_mag_a,
   output logic [7:0]                         rsp_mag_b,
   output logic [7:0]                         rsp_mag_c,
   input  logic                               csr_we,
   input  logic [sgm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sgm_pkg::SIZE_W-1:0]         csr_wdata
);

   import sgm_pkg::*;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic              adv, accept;
   pix_type           px;
   win_type           win;
   meta_type          s1_meta;
   meta_type          s2_meta_ff, s3_meta_ff, s4_meta_ff, out_meta_ff;
   logic [CHAN_W-1:0] mag [NUM_CHAN];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata;
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or being taken.
   assign adv       = !out_meta_ff.emit || !rsp_stall;
   assign accept    = req_valid && adv;
   assign req_stall = !adv;
   assign px        = {req_chan_c, req_chan_b, req_chan_a};

   sgm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .frame_start (req_frame_start),
      .px          (px),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .win         (win),
      .meta        (s1_meta)
   );

   for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
      logic [WIN_N-1:0][CHAN_W-1:0] chan_win;

      always_comb begin
         for (int i = 0; i < WIN_N; i++) begin
            chan_win[i] = win[i][CHAN_W*k +: CHAN_W];
         end
      end

      sgm_mag u_mag (
         .clock (clock),
         .adv   (adv),
         .win   (chan_win),
         .mag   (mag[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_meta_ff.emit  <= 1'b0;
         s3_meta_ff.emit  <= 1'b0;
         s4_meta_ff.emit  <= 1'b0;
         out_meta_ff.emit <= 1'b0;
      end else if (adv) begin
         s2_meta_ff  <= s1_meta;
         s3_meta_ff  <= s2_meta_ff;
         s4_meta_ff  <= s3_meta_ff;
         out_meta_ff <= s4_meta_ff;
      end
   end

   assign rsp_valid   = out_meta_ff.emit;
   assign rsp_out_row = out_meta_ff.row;
   assign rsp_out_col = out_meta_ff.col;
   assign rsp_mag_a   = mag[0];
   assign rsp_mag_b   = mag[1];
   assign rsp_mag_c   = mag[2];

endmodule

// ===== hdl/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// sgm_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and only
// changes when a read is enabled. A read of the entry being written returns
// the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sgm_front.sv =====
// ----------------------------------------------------------------------------
// sgm_front: position tracking, line memory and window assembly
// Tracks the raster position, reads the two stored rows for the incoming
// column, writes them back shifted by one row and builds the 3x3 window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          accept,
   input  logic                          frame_start,
   input  sgm_pkg::pix_type              px,
   input  logic [sgm_pkg::SIZE_W-1:0]    cfg_width,
   input  logic [sgm_pkg::SIZE_W-1:0]    cfg_height,
   output sgm_pkg::win_type              win,
   output sgm_pkg::meta_type             meta
);

   import sgm_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int SW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          s1_valid_ff;
   pix_type       s1_px_ff;
   logic [CW-1:0] s1_col_ff;
   meta_type      s1_meta_ff, s1_meta_in;
   logic          s1_fwd_ff, s1_fwd_in;
   logic [2*PIX_W-1:0] s1_fwd_data_ff;

   pix_type       win_ff [6];

   logic [SW-1:0] w_use;
   logic [HW-1:0] h_use;
   logic [31:0]   w_req, h_req;
   logic [CW-1:0] col_cur;
   logic [RW-1:0] row_cur;
   logic [SW-1:0] col_nx;
   logic [HW-1:0] row_nx;
   logic [31:0]   row_m1, col_m1;

   logic [2*PIX_W-1:0] rd_data, lines, wr_data;
   pix_type            top, mid;
   logic               wr_en;

   // Size in use is clamped to the supported range; the register keeps its bits.
   always_comb begin
      w_req = 32'(cfg_width);
      h_req = 32'(cfg_height);
      if (w_req < 32'(MIN_SIZE)) begin
         w_use = SW'(MIN_SIZE);
      end else if (w_req > 32'(MAX_WIDTH)) begin
         w_use = SW'(MAX_WIDTH);
      end else begin
         w_use = SW'(w_req);
      end
      if (h_req < 32'(MIN_SIZE)) begin
         h_use = HW'(MIN_SIZE);
      end else if (h_req > 32'(MAX_HEIGHT)) begin
         h_use = HW'(MAX_HEIGHT);
      end else begin
         h_use = HW'(h_req);
      end
   end

   always_comb begin
      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;
      col_nx  = SW'(col_cur) + SW'(1);
      row_nx  = HW'(row_cur) + HW'(1);
      col_in  = col_cur;
      row_in  = row_cur;
      // The position wraps as soon as it reaches or passes the size in use.
      if (col_nx >= w_use) begin
         col_in = '0;
         if (row_nx >= h_use) begin
            row_in = '0;
         end else begin
            row_in = RW'(row_nx);
         end
      end else begin
         col_in = CW'(col_nx);
      end
      row_m1 = 32'(row_cur) - 32'd1;
      col_m1 = 32'(col_cur) - 32'd1;
      s1_meta_in.emit = (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2);
      s1_meta_in.row  = row_m1[POS_W-1:0];
      s1_meta_in.col  = col_m1[POS_W-1:0];
      // The item in stage one writes this same column in this cycle.
      s1_fwd_in = s1_valid_ff && (s1_col_ff == col_cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && accept) begin
         s1_px_ff       <= px;
         s1_col_ff      <= col_cur;
         s1_meta_ff     <= s1_meta_in;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= wr_data;
      end
   end

   sgm_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (rd_data)
   );

   // Upper half holds row r-2, lower half row r-1.
   always_comb begin
      lines   = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
      top     = lines[2*PIX_W-1:PIX_W];
      mid     = lines[PIX_W-1:0];
      wr_data = {mid, s1_px_ff};
      wr_en   = adv && s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (wr_en) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= win_ff[i+3];
         end
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_px_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         win[i] = win_ff[i];
      end
      win[6]    = top;
      win[7]    = mid;
      win[8]    = s1_px_ff;
      meta      = s1_meta_ff;
      meta.emit = s1_meta_ff.emit && s1_valid_ff;
   end

endmodule

// ===== hdl/sgm_mag.sv =====
// ----------------------------------------------------------------------------
// sgm_mag: Sobel gradient magnitude of one channel
// Four register stages: gradients, sum of squares, upper root digits,
// lower root digits with saturation at 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_mag (
   input  logic                                      clock,
   input  logic                                      adv,
   input  logic [sgm_pkg::WIN_N-1:0][sgm_pkg::CHAN_W-1:0] win,
   output logic [sgm_pkg::CHAN_W-1:0]                mag
);

   import sgm_pkg::*;

   logic signed [10:0] tl, ml, bl, tc, bc, tr, mr, br;
   logic signed [10:0] gx_ff, gx_in, gy_ff, gy_in;
   logic signed [21:0] gxe, gye;
   logic [21:0]        sum_in;
   logic               sat3_ff, sat4_ff;
   logic [15:0]        n_ff;
   sqrt_type           hi_ff, hi_in, lo_in;
   logic [7:0]         lo_ff;
   logic [CHAN_W-1:0]  mag_ff;

   always_comb begin
      tl = $signed({3'b000, win[0]});
      ml = $signed({3'b000, win[1]});
      bl = $signed({3'b000, win[2]});
      tc = $signed({3'b000, win[3]});
      bc = $signed({3'b000, win[5]});
      tr = $signed({3'b000, win[6]});
      mr = $signed({3'b000, win[7]});
      br = $signed({3'b000, win[8]});
      gx_in = (tr - tl) + (mr - ml) + (mr - ml) + (br - bl);
      gy_in = (bl - tl) + (bc - tc) + (bc - tc) + (br - tr);
   end

   always_comb begin
      gxe    = 22'(gx_ff);
      gye    = 22'(gy_ff);
      sum_in = gxe * gxe + gye * gye;
   end

   // Radicand below 65536 gives an eight-bit root; the upper byte is done first.
   always_comb begin
      hi_in = '0;
      for (int i = 0; i < 4; i++) begin
         hi_in = sqrt_step(hi_in, n_ff[15-2*i -: 2]);
      end
      lo_in = hi_ff;
      for (int i = 0; i < 4; i++) begin
         lo_in = sqrt_step(lo_in, lo_ff[7-2*i -: 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         sat3_ff <= (sum_in[21:16] != 6'd0);
         n_ff    <= sum_in[15:0];
         hi_ff   <= hi_in;
         lo_ff   <= n_ff[7:0];
         sat4_ff <= sat3_ff;
         mag_ff  <= sat4_ff ? {CHAN_W{1'b1}} : lo_in.root;
      end
   end

   assign mag = mag_ff;

endmodule
